>>> design/bpfp_pkg.sv
// Package for the breakpoint packet field parser.
// Holds the parse phase type, the result payload type, the character
// constants and the hex decode function. No dependencies.
package bpfp_pkg;

  localparam int unsigned MAX_DIGITS = 8;
  localparam int unsigned COUNT_W    = $clog2(MAX_DIGITS + 1);
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned LEN_W      = 31;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TYPE,
    PH_COMMA,
    PH_ADDR,
    PH_LEN
  } phase_t;

  typedef struct packed {
    logic              ok;
    logic [3:0]        bp_type;
    logic [ACC_W-1:0]  address;
    logic [LEN_W-1:0]  length;
  } result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.is_hex = 1'b1;
    h.nib    = 4'h0;
    if (c >= CH_0 && c <= CH_9) begin
      h.nib = 4'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LF) begin
      h.nib = 4'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UF) begin
      h.nib = 4'(c - CH_UA + 8'd10);
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> design/bpfp_if.sv
// Valid/ready channel interfaces for the breakpoint packet field parser.
// Depends on bpfp_pkg for field widths.
interface bpfp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       first;

  modport source (output valid, output ch, output first, input ready);
  modport sink (input valid, input ch, input first, output ready);
endinterface

interface bpfp_result_if;
  import bpfp_pkg::*;
  logic             valid;
  logic             ready;
  logic             ok;
  logic [3:0]       bp_type;
  logic [ACC_W-1:0] address;
  logic [LEN_W-1:0] length;

  modport source (output valid, output ok, output bp_type, output address,
                  output length, input ready);
  modport sink (input valid, input ok, input bp_type, input address,
                input length, output ready);
endinterface

>>> design/breakpoint_packet_field_parser.sv
// Breakpoint packet field parser top level.
// Depends on bpfp_pkg and the channel interfaces in bpfp_if.sv.
//
//   channel  direction  payload
//   item     in         ch[7:0], first
//   result   out        ok, bp_type[3:0], address[31:0], length[30:0]
//
// One character is taken per cycle unless item stalls; its result, if any,
// is registered in the result register, or in the skid register while the
// output is stalled. The parse state is registered from each accepted
// character. Item stalls only when both result registers are full.
// Reset is synchronous and returns the parser to idle with no result pending.
module breakpoint_packet_field_parser
  import bpfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  bpfp_char_if.sink    item,
  bpfp_result_if.source result
);

  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] digit_count, digit_count_next;
  logic [ACC_W-1:0]   accumulator, accumulator_next;
  logic [3:0]         held_type, held_type_next;
  logic [ACC_W-1:0]   held_address, held_address_next;

  result_t out_reg, skid_reg, res_new;
  logic    out_valid, skid_valid, res_fire;
  logic    take, pop;
  hex_t    hx;

  assign item.ready = !skid_valid;
  assign take       = item.valid && item.ready;
  assign pop        = out_valid && result.ready;
  assign hx         = hex_decode(item.ch);

  always_comb begin
    phase_next        = phase;
    digit_count_next  = digit_count;
    accumulator_next  = accumulator;
    held_type_next    = held_type;
    held_address_next = held_address;
    res_fire          = 1'b0;
    res_new           = '0;
    if (item.first) begin
      phase_next        = PH_TYPE;
      digit_count_next  = '0;
      accumulator_next  = '0;
      held_type_next    = 4'h0;
      held_address_next = '0;
    end else begin
      case (phase)
        PH_TYPE: begin
          if (hx.is_hex) begin
            held_type_next = hx.nib;
            phase_next     = PH_COMMA;
          end else begin
            res_fire = 1'b1;
          end
        end
        PH_COMMA: begin
          if (item.ch == CH_COMMA) begin
            digit_count_next = '0;
            accumulator_next = '0;
            phase_next       = PH_ADDR;
          end else begin
            res_fire = 1'b1;
          end
        end
        PH_ADDR, PH_LEN: begin
          if (hx.is_hex) begin
            if (digit_count >= COUNT_W'(MAX_DIGITS)) begin
              res_fire = 1'b1;
            end else begin
              accumulator_next = {accumulator[ACC_W-5:0], hx.nib};
              digit_count_next = digit_count + 1'b1;
            end
          end else if (digit_count == '0) begin
            res_fire = 1'b1;
          end else if (phase == PH_ADDR) begin
            if (item.ch == CH_COMMA) begin
              held_address_next = accumulator;
              digit_count_next  = '0;
              accumulator_next  = '0;
              phase_next        = PH_LEN;
            end else begin
              res_fire = 1'b1;
            end
          end else begin
            res_fire = 1'b1;
            // Length must be nonzero and fit in 31 bits.
            if (accumulator != '0 && !accumulator[ACC_W-1]) begin
              res_new.ok      = 1'b1;
              res_new.bp_type = held_type;
              res_new.address = held_address;
              res_new.length  = accumulator[LEN_W-1:0];
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
      if (res_fire) begin
        phase_next       = PH_IDLE;
        digit_count_next = '0;
        accumulator_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      digit_count  <= '0;
      accumulator  <= '0;
      held_type    <= 4'h0;
      held_address <= '0;
    end else if (take) begin
      phase        <= phase_next;
      digit_count  <= digit_count_next;
      accumulator  <= accumulator_next;
      held_type    <= held_type_next;
      held_address <= held_address_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          out_reg    <= skid_reg;
          skid_valid <= 1'b0;
        end
      end else if (take && res_fire) begin
        if (!out_valid || pop) begin
          out_reg   <= res_new;
          out_valid <= 1'b1;
        end else begin
          skid_reg   <= res_new;
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid   = out_valid;
  assign result.ok      = out_reg.ok;
  assign result.bp_type = out_reg.bp_type;
  assign result.address = out_reg.address;
  assign result.length  = out_reg.length;

endmodule
